@@ design/ttc_pkg.sv @@
// shared constants and register codes for the thermistor temperature converter
`timescale 1ns / 1ps
`default_nettype none

package ttc_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_C      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORR_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CORR_OFFSET = 3'd4;

  // register reset values
  localparam logic signed [47:0] COEF_A_RST      = 48'sd40140010000000;
  localparam logic signed [47:0] COEF_B_RST      = 48'sd23879200000000;
  localparam logic signed [47:0] COEF_C_RST      = -48'sd24687500000;
  localparam logic [15:0]        CORR_GAIN_RST   = 16'd16384;
  localparam logic signed [15:0] CORR_OFFSET_RST = 16'sd0;

  // sample window where the divider gives a positive resistance
  localparam logic signed [15:0] S_SINGULAR = 16'sd13200;
  localparam logic signed [15:0] S_TOP      = 16'sd26400;
  localparam logic [26:0]        R_SCALE    = 27'd5000;

  // fixed point constants
  localparam logic signed [30:0] LN2_Q30    = 31'sd744261118;
  localparam logic signed [58:0] KELVIN_Q16 = 59'sd17901158;
  localparam logic signed [58:0] TC_HI      = 59'sd1099511627776;
  localparam logic signed [58:0] TC_LO      = -59'sd1099511627776;
  localparam logic signed [36:0] OUT_HI     = 37'sd65535;
  localparam logic signed [36:0] OUT_LO     = -37'sd65536;

  // pipeline depths of the arithmetic units
  localparam int unsigned MUL_LAT = 6;
  localparam int unsigned DIV_QW  = 57;
  localparam int unsigned DIV_LAT = DIV_QW + 2;

endpackage

`default_nettype wire

@@ design/thermistor_temperature_converter_core.sv @@
// thermistor sample to temperature converter, top level
// Converts one signed ADC code (0.125 mV per bit) from a divider with a 10k series and
// a 10k parallel resistor into a Steinhart-Hart temperature in 1/256 degree Celsius,
// corrected by gain and offset and saturated to 17 bits signed.
// Channels: input raw_sample_i with in_valid_i / in_stall_o, output temperature_o and
// valid_res_o with out_valid_o / out_stall_i; a transaction moves at an edge where
// valid is high and stall is low. Coefficients come in through cfg_we_i, cfg_idx_i and
// cfg_data_i; they must be written only while the converter is empty, but the block
// does not enforce this. Throughput: one sample per cycle while in_stall_o is low.
// The pipeline holds the 28 squaring stages of the two log2 units, six 6-stage
// multipliers (five of them in series) and the 59-stage restoring divider.
// valid_res_o is low (and temperature_o zero) for samples at or below the singular
// divider point and at or above S_TOP, where the resistance is not positive.
// Reset clears all pipeline valid bits and loads the default coefficients.
// When out_stall_i holds a result, one more result moves into an output skid register;
// the pipeline then freezes and in_stall_o rises until the skid register drains.
`timescale 1ns / 1ps
`default_nettype none

module thermistor_temperature_converter_core
  import ttc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic signed [15:0]    raw_sample_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [16:0]         temperature_o,
  output logic                       valid_res_o
);

  localparam int unsigned L   = MUL_LAT;
  localparam int unsigned LAT = 39 + 5 * MUL_LAT + DIV_LAT;

  // configuration registers
  logic signed [47:0] coef_a_q, coef_b_q, coef_c_q;
  logic [15:0]        corr_gain_q;
  logic signed [15:0] corr_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q      <= COEF_A_RST;
      coef_b_q      <= COEF_B_RST;
      coef_c_q      <= COEF_C_RST;
      corr_gain_q   <= CORR_GAIN_RST;
      corr_offset_q <= CORR_OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COEF_A:      coef_a_q      <= cfg_data_i;
        CFG_COEF_B:      coef_b_q      <= cfg_data_i;
        CFG_COEF_C:      coef_c_q      <= cfg_data_i;
        CFG_CORR_GAIN:   corr_gain_q   <= cfg_data_i[15:0];
        CFG_CORR_OFFSET: corr_offset_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // pipeline advance and output skid register
  logic en;
  logic skid_v_q, skid_v_d;
  logic signed [16:0] skid_temp_q, temp_q;
  logic skid_vres_q;
  logic [LAT-1:0] vld_q, ok_q;
  logic ok_in;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_comb begin
    if (skid_v_q) begin
      skid_v_d = out_stall_i;
    end else begin
      skid_v_d = vld_q[LAT-1] && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q) begin
      skid_temp_q <= temp_q;
      skid_vres_q <= ok_q[LAT-1];
    end
  end

  assign out_valid_o   = skid_v_q || vld_q[LAT-1];
  assign temperature_o = skid_v_q ? skid_temp_q : temp_q;
  assign valid_res_o   = skid_v_q ? skid_vres_q : ok_q[LAT-1];

  // valid and range flags travel with the data
  assign ok_in = (raw_sample_i > S_SINGULAR) && (raw_sample_i < S_TOP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q <= {ok_q[LAT-2:0], ok_in};
    end
  end

  // input register, divider numerator and denominator
  logic signed [15:0] s_q;
  logic [15:0] nd_w;
  logic [26:0] n_q;
  logic [13:0] d_q;

  assign nd_w = 16'(S_TOP - s_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q <= raw_sample_i;
      n_q <= 27'(nd_w[13:0]) * R_SCALE;
      d_q <= 14'(s_q - S_SINGULAR);
    end
  end

  // leading one position
  function automatic logic [4:0] msb27(input logic [26:0] v);
    logic [4:0] k;
    k = '0;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) k = 5'(i);
    end
    return k;
  endfunction

  function automatic logic [3:0] msb14(input logic [13:0] v);
    logic [3:0] k;
    k = '0;
    for (int i = 0; i < 14; i++) begin
      if (v[i]) k = 4'(i);
    end
    return k;
  endfunction

  // log2 units: normalize, then one squaring per stage
  logic [30:0] mn_q [0:28];
  logic [30:0] md_q [0:28];
  logic [4:0]  kn_q [0:28];
  logic [3:0]  kd_q [0:28];
  logic [27:0] fn_q [0:28];
  logic [27:0] fd_q [0:28];
  logic [4:0]  kn_d;
  logic [3:0]  kd_d;

  assign kn_d = msb27(n_q);
  assign kd_d = msb14(d_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mn_q[0] <= 31'(n_q) << (5'd30 - kn_d);
      md_q[0] <= 31'(d_q) << (5'd30 - {1'b0, kd_d});
      kn_q[0] <= kn_d;
      kd_q[0] <= kd_d;
      fn_q[0] <= '0;
      fd_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < 28; i++) begin : g_log
    logic [61:0] sqn, sqd;
    logic [31:0] hn, hd;

    assign sqn = mn_q[i] * mn_q[i];
    assign sqd = md_q[i] * md_q[i];
    assign hn  = sqn[61:30];
    assign hd  = sqd[61:30];

    always_ff @(posedge clk_i) begin
      if (en) begin
        mn_q[i+1] <= hn[31] ? hn[31:1] : hn[30:0];
        md_q[i+1] <= hd[31] ? hd[31:1] : hd[30:0];
        fn_q[i+1] <= {fn_q[i][26:0], hn[31]};
        fd_q[i+1] <= {fd_q[i][26:0], hd[31]};
        kn_q[i+1] <= kn_q[i];
        kd_q[i+1] <= kd_q[i];
      end
    end
  end

  // log2 ratio, Q28
  logic signed [34:0] diff_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      diff_q <= $signed({2'b00, kn_q[28], fn_q[28]}) - $signed({3'b000, kd_q[28], fd_q[28]});
    end
  end

  // natural log and its powers
  logic signed [33:0] lnr;
  logic signed [37:0] x2;
  logic signed [41:0] x3;
  logic signed [53:0] bl;
  logic signed [61:0] cx;
  logic signed [33:0] lnr_dly_q [0:L-1];
  logic signed [54:0] abl_q [0:L-1];

  ttc_mul #(.AW(35), .BW(31), .SH(30), .OW(34)) u_mul_ln (
    .clk_i (clk_i), .en_i (en), .a_i (diff_q), .b_i (LN2_Q30), .p_o (lnr)
  );

  ttc_mul #(.AW(34), .BW(34), .SH(28), .OW(38)) u_mul_x2 (
    .clk_i (clk_i), .en_i (en), .a_i (lnr), .b_i (lnr), .p_o (x2)
  );

  ttc_mul #(.AW(38), .BW(34), .SH(28), .OW(42)) u_mul_x3 (
    .clk_i (clk_i), .en_i (en), .a_i (x2), .b_i (lnr_dly_q[L-1]), .p_o (x3)
  );

  ttc_mul #(.AW(48), .BW(34), .SH(28), .OW(54)) u_mul_b (
    .clk_i (clk_i), .en_i (en), .a_i (coef_b_q), .b_i (lnr_dly_q[L-1]), .p_o (bl)
  );

  ttc_mul #(.AW(48), .BW(42), .SH(28), .OW(62)) u_mul_c (
    .clk_i (clk_i), .en_i (en), .a_i (coef_c_q), .b_i (x3), .p_o (cx)
  );

  // delay lines that keep operands aligned with the multipliers
  always_ff @(posedge clk_i) begin
    if (en) begin
      lnr_dly_q[0] <= lnr;
      abl_q[0]     <= 55'(coef_a_q) + 55'(bl);
      for (int j = 1; j < L; j++) begin
        lnr_dly_q[j] <= lnr_dly_q[j-1];
        abl_q[j]     <= abl_q[j-1];
      end
    end
  end

  // denominator, then rounded to Q40 magnitude
  logic signed [62:0] den_q;
  logic [61:0] dabs_q;
  logic        dneg_q, neg2_q;
  logic [62:0] dsum;
  logic [45:0] mag_q;

  assign dsum = {1'b0, dabs_q} + 63'd32768;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q  <= 63'(abl_q[L-1]) + 63'(cx);
      dneg_q <= den_q[62];
      dabs_q <= den_q[62] ? 62'(-den_q) : 62'(den_q);
      neg2_q <= dneg_q;
      mag_q  <= dsum[61:16];
    end
  end

  // kelvin from the reciprocal
  logic signed [57:0] tk;

  ttc_div #(.MW(46), .QW(DIV_QW)) u_div (
    .clk_i (clk_i), .en_i (en), .mag_i (mag_q), .neg_i (neg2_q), .tk_o (tk)
  );

  // celsius, clamped
  logic signed [58:0] tcr_q;
  logic signed [41:0] tc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tcr_q <= 59'(tk) - KELVIN_Q16;
      priority if (tcr_q > TC_HI) begin
        tc_q <= 42'(TC_HI);
      end else if (tcr_q < TC_LO) begin
        tc_q <= 42'(TC_LO);
      end else begin
        tc_q <= 42'(tcr_q);
      end
    end
  end

  // gain, offset and output saturation
  logic signed [35:0] gp;
  logic signed [36:0] ts_q;

  ttc_mul #(.AW(17), .BW(42), .SH(22), .OW(36)) u_mul_gain (
    .clk_i (clk_i), .en_i (en), .a_i ($signed({1'b0, corr_gain_q})), .b_i (tc_q), .p_o (gp)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      ts_q <= 37'(gp) + 37'(corr_offset_q);
      priority if (!ok_q[LAT-2]) begin
        temp_q <= '0;
      end else if (ts_q > OUT_HI) begin
        temp_q <= 17'(OUT_HI);
      end else if (ts_q < OUT_LO) begin
        temp_q <= 17'(OUT_LO);
      end else begin
        temp_q <= ts_q[16:0];
      end
    end
  end

  // checks
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (temperature_o == '0))
    else $error("invalid reading with nonzero temperature");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a held output");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted sample missing from first stage");

endmodule

`default_nettype wire

@@ design/ttc_mul.sv @@
// pipelined signed multiply with rounded right shift, split into partial products
`timescale 1ns / 1ps
`default_nettype none

module ttc_mul #(
  parameter int unsigned AW = 48,
  parameter int unsigned BW = 42,
  parameter int unsigned SH = 28,
  parameter int unsigned OW = 62
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [AW-1:0] a_i,
  input  wire logic signed [BW-1:0] b_i,
  output logic signed [OW-1:0]      p_o
);

  localparam int unsigned LA = AW / 2;
  localparam int unsigned HA = AW - LA;
  localparam int unsigned LB = BW / 2;
  localparam int unsigned HB = BW - LB;
  localparam int unsigned PW = AW + BW;
  localparam logic [PW:0] RND = (PW+1)'(1) << (SH - 1);

  logic [AW-1:0] ua, ma_d, ma_q;
  logic [BW-1:0] ub, mb_d, mb_q;
  logic [4:0]    neg_q;
  logic [LA+LB-1:0] pll_q, ll_q;
  logic [LA+HB-1:0] plh_q;
  logic [HA+LB-1:0] phl_q;
  logic [HA+HB-1:0] phh_q, hh_q;
  logic [PW-1:0]    mid_q, full_q;
  logic [PW:0]      rsum;
  logic [PW-SH:0]   rnd_q;
  logic [PW+1:0]    ext, res;
  logic [OW-1:0]    p_q;

  // magnitudes of the operands
  assign ua   = a_i;
  assign ub   = b_i;
  assign ma_d = ua[AW-1] ? (~ua + 1'b1) : ua;
  assign mb_d = ub[BW-1] ? (~ub + 1'b1) : ub;

  // rounding half away from zero on the magnitude
  assign rsum = {1'b0, full_q} + RND;
  assign ext  = {{(SH+1){1'b0}}, rnd_q};
  assign res  = neg_q[4] ? (~ext + 1'b1) : ext;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // sign and magnitude
      neg_q <= {neg_q[3:0], a_i[AW-1] ^ b_i[BW-1]};
      ma_q  <= ma_d;
      mb_q  <= mb_d;
      // four partial products
      pll_q <= ma_q[LA-1:0] * mb_q[LB-1:0];
      plh_q <= ma_q[LA-1:0] * mb_q[BW-1:LB];
      phl_q <= ma_q[AW-1:LA] * mb_q[LB-1:0];
      phh_q <= ma_q[AW-1:LA] * mb_q[BW-1:LB];
      // cross terms
      mid_q <= (PW'(phl_q) << LA) + (PW'(plh_q) << LB);
      ll_q  <= pll_q;
      hh_q  <= phh_q;
      // full product
      full_q <= {hh_q, ll_q} + mid_q;
      // round and shift
      rnd_q <= rsum[PW:SH];
      // restore sign
      p_q <= res[OW-1:0];
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ design/ttc_div.sv @@
// pipelined restoring divider giving a rounded signed reciprocal
`timescale 1ns / 1ps
`default_nettype none

module ttc_div #(
  parameter int unsigned MW = 46,
  parameter int unsigned QW = 57
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [MW-1:0]     mag_i,
  input  wire logic              neg_i,
  output logic signed [QW:0]     tk_o
);

  localparam logic [QW-1:0] NUM_BASE = {1'b1, {(QW-1){1'b0}}};

  logic [QW-1:0] num_q  [0:QW-1];
  logic [MW-1:0] mag_q  [0:QW-1];
  logic [MW-1:0] rem_q  [0:QW-1];
  logic [QW-1:0] quo_q  [0:QW];
  logic          neg_q  [0:QW];
  logic          zero_q [0:QW];
  logic [QW:0]   qext, qres;
  logic signed [QW:0] tk_q;

  // numerator carries half the divisor for rounding
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0]  <= NUM_BASE + QW'(mag_i[MW-1:1]);
      mag_q[0]  <= mag_i;
      rem_q[0]  <= '0;
      quo_q[0]  <= '0;
      neg_q[0]  <= neg_i;
      zero_q[0] <= (mag_i == '0);
    end
  end

  // one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [MW:0] trial, dif;
    logic        ge;

    assign trial = {rem_q[j], num_q[j][QW-1]};
    assign ge    = trial >= {1'b0, mag_q[j]};
    assign dif   = trial - {1'b0, mag_q[j]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j+1]  <= {quo_q[j][QW-2:0], ge};
        neg_q[j+1]  <= neg_q[j];
        zero_q[j+1] <= zero_q[j];
      end
    end

    if (j < QW - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j+1] <= ge ? dif[MW-1:0] : trial[MW-1:0];
          num_q[j+1] <= num_q[j] << 1;
          mag_q[j+1] <= mag_q[j];
        end
      end
    end
  end

  // sign and zero divisor override
  assign qext = {1'b0, quo_q[QW]};
  assign qres = neg_q[QW] ? (~qext + 1'b1) : qext;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tk_q <= zero_q[QW] ? $signed({1'b0, NUM_BASE}) : $signed(qres);
    end
  end

  assign tk_o = tk_q;

endmodule

`default_nettype wire
